/* design/assert_macros.svh */
// Assertion macros shared by the SM3 hash engine RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check that is held off while the reset is asserted.
`define SM3_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Concurrent check that also holds during reset.
`define SM3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SM3_ASSERT(lbl, clk, rstn, prop, msg)
`define SM3_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* design/sm3_pkg.sv */
// Types, constants and helper functions for the SM3 hash engine.
// No dependencies.
package sm3_pkg;

  typedef struct packed {
    logic [31:0] msg_word;
    logic        start_message;
    logic        last_block;
  } sm3_in_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_midhigh;
    logic [63:0] digest_midlow;
    logic [63:0] digest_low;
  } sm3_out_t;

  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 64;

  localparam logic [31:0] TLow  = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;
  // Round constant of round 16, the first round that uses THigh.
  localparam logic [31:0] THighRot16 = {THigh[15:0], THigh[31:16]};

  localparam logic [7:0][31:0] InitVector = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(logic [31:0] x);
    return x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(logic [31:0] x);
    return x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

endpackage

/* design/sm3_hash_engine.sv */
// SM3 hash engine top level: word collection, message expansion and round unit.
// Depends on sm3_pkg and assert_macros.svh.
//
// The engine takes one padded 32-bit word per request and is ready again in the
// next cycle for words 0 to 14 of a block. The 16th word starts the compression,
// which runs one SM3 round per cycle through a single round unit and a 16-word
// sliding expansion window, so the engine is not ready while the rounds run.
// After the final block the emit state moves the chain value into the digest
// register, which holds it until it is taken; if an earlier digest has not been
// taken yet, the emit state waits for it.
`include "assert_macros.svh"

module sm3_hash_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sm3_pkg::sm3_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sm3_pkg::sm3_out_t out_data_o
);
  import sm3_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCompress,
    StEmit
  } state_e;

  state_e           state_q;
  logic [3:0]       cnt_q;
  logic [5:0]       round_q;
  logic             last_q;
  logic             out_valid_q;
  sm3_out_t         out_data_q;
  logic [7:0][31:0] chain_q;

  logic [15:0][31:0] win_q, win_d;
  logic [7:0][31:0]  v_q, v_rnd;
  logic [31:0]       t_q;

  logic        in_acc, out_acc, blk_done, rnd_last;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic [7:0][31:0] chain_next;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign blk_done    = in_acc && !in_data_i.start_message && (cnt_q == 4'(NumWords - 1));
  assign rnd_last    = (round_q == 6'(NumRounds - 1));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // One SM3 round; v_q[0] is A and v_q[7] is H.
  always_comb begin
    a12 = rotl32(v_q[0], 12);
    ss1 = rotl32(a12 + v_q[4] + t_q, 7);
    ss2 = ss1 ^ a12;
    if (round_q[5:4] == 2'b00) begin
      ff = v_q[0] ^ v_q[1] ^ v_q[2];
      gg = v_q[4] ^ v_q[5] ^ v_q[6];
    end else begin
      ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
      gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
    end
    tt1 = ff + v_q[3] + ss2 + (win_q[0] ^ win_q[4]);
    tt2 = gg + v_q[7] + ss1 + win_q[0];
    v_rnd[0] = tt1;
    v_rnd[1] = v_q[0];
    v_rnd[2] = rotl32(v_q[1], 9);
    v_rnd[3] = v_q[2];
    v_rnd[4] = perm0(tt2);
    v_rnd[5] = v_q[4];
    v_rnd[6] = rotl32(v_q[5], 19);
    v_rnd[7] = v_q[6];
    chain_next = chain_q ^ v_rnd;
  end

  // The window holds W[j] .. W[j+15]; each round shifts in W[j+16].
  always_comb begin
    w_new = perm1(win_q[0] ^ win_q[7] ^ rotl32(win_q[13], 15))
            ^ rotl32(win_q[3], 7) ^ win_q[10];
    for (int i = 0; i < 15; i++) begin
      win_d[i] = win_q[i + 1];
    end
    win_d[15] = in_acc ? in_data_i.msg_word : w_new;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc || state_q == StCompress) begin
      win_q <= win_d;
    end
    if (blk_done) begin
      v_q <= chain_q;
      t_q <= TLow;
    end else if (state_q == StCompress) begin
      v_q <= v_rnd;
      if (round_q == 6'(NumWords - 1)) begin
        t_q <= THighRot16;
      end else begin
        t_q <= {t_q[30:0], t_q[31]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      round_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      chain_q     <= InitVector;
    end else begin
      // A new digest may replace one that is being taken in the same cycle.
      if (state_q == StEmit && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (in_data_i.start_message) begin
              chain_q <= InitVector;
              cnt_q   <= 4'd1;
            end else begin
              cnt_q <= cnt_q + 4'd1;
            end
            if (blk_done) begin
              last_q  <= in_data_i.last_block;
              round_q <= '0;
              state_q <= StCompress;
            end
          end
        end
        StCompress: begin
          round_q <= round_q + 6'd1;
          if (rnd_last) begin
            chain_q <= chain_next;
            state_q <= last_q ? StEmit : StIdle;
          end
        end
        StEmit: begin
          if (!out_valid_q || out_ready_i) begin
            out_data_q  <= '{digest_high:    {chain_q[0], chain_q[1]},
                             digest_midhigh: {chain_q[2], chain_q[3]},
                             digest_midlow:  {chain_q[4], chain_q[5]},
                             digest_low:     {chain_q[6], chain_q[7]}};
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // A compression always starts at round zero with the word counter cleared.
  `SM3_ASSERT(a_comp_start, clk_i, rst_ni, blk_done |=> (state_q == StCompress && round_q == '0 && cnt_q == '0), "compression did not start cleanly")
  // The round counter only moves during compression.
  `SM3_ASSERT(a_round_idle, clk_i, rst_ni, (state_q != StCompress) |=> $stable(round_q) || state_q == StCompress, "round counter moved outside compression")
  // The digest is only offered after a final block.
  `SM3_ASSERT(a_emit_src, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q) == StEmit, "digest appeared without a final block")
  // The emit state is only reached from the last round of a final block.
  `SM3_ASSERT(a_emit_entry, clk_i, rst_ni, (state_q == StEmit && $past(state_q) != StEmit) |-> ($past(rnd_last) && $past(last_q)), "emit entered out of sequence")
  // Words are never taken while rounds are running.
  `SM3_ASSERT_ALWAYS(a_no_accept, clk_i, !(in_acc && state_q == StCompress), "word taken during compression")

endmodule
